// File: sv/bptc_pkg.sv
// ----------------------------------------------------------------------------
// bptc_pkg
// shared widths, register indexes and helpers for the compensation unit
// ----------------------------------------------------------------------------
package bptc_pkg;

  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned OutUserW = 2;

  localparam logic [1:0] RegTempCalib = 2'd0;
  localparam logic [1:0] RegPressLo   = 2'd1;
  localparam logic [1:0] RegPressHi   = 2'd2;
  localparam logic [1:0] RegPressP9   = 2'd3;

  localparam logic CmdTemp  = 1'b0;
  localparam logic CmdPress = 1'b1;

  localparam logic [63:0] FineOffset = 64'd128000;
  localparam logic [31:0] PressFull  = 32'd1048576;
  localparam logic [63:0] PressScale = 64'd3125;
  localparam logic [31:0] RoundHalf  = 32'd128;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx32(input logic [31:0] v);
    sx32 = {{32{v[31]}}, v};
  endfunction

endpackage

// File: sv/baro_temp_pressure_compensation_unit.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_unit
// fixed-point temperature and pressure compensation for a barometer
// ----------------------------------------------------------------------------
// One transaction at a time: a temperature transaction makes three passes
// through the shared multiplier, a pressure transaction ten multiplier
// passes and one run of the bit-serial divider, and it stops before the
// divider when the divisor is zero.
// s_tready is low while a transaction is in work; the result sits in an
// output register so the next transaction is taken while it waits, and a
// finished result that still finds the output register full holds the unit.
// Calibration registers sit at byte addresses 0, 8, 16 and 24.
module baro_temp_pressure_compensation_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bptc_pkg::CfgAddrW-1:0] paddr,
  input  logic [bptc_pkg::CfgDataW-1:0] pwdata,
  output logic [bptc_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // raw_sample [19:0], zero [23:20]
  input  logic [bptc_pkg::InDataW-1:0]  s_tdata,
  // command [0]
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // temperature_centi [31:0], pressure_q24_8 [63:32]
  output logic [bptc_pkg::OutDataW-1:0] m_tdata,
  // result_kind [0], divide_guard [1]
  output logic [bptc_pkg::OutUserW-1:0] m_tuser
);

  typedef enum logic [4:0] {
    SIdle, STa, STb, STc, SPs, SPv2a, SPv2b, SPc3, SPc2, SPp1,
    SPnum, SPdiv, SPq1a, SPq1b, SPq2, SDone
  } state_t;

  state_t      st;
  logic        launched;
  logic        mstart;
  logic [63:0] ma;
  logic [63:0] mb;
  logic        mdone;
  logic [63:0] prod;
  logic        dstart;
  logic        ddone;
  logic [63:0] dq;

  logic [47:0] temp_calib;
  logic [63:0] press_lo;
  logic [63:0] press_hi;
  logic [15:0] press_p9;
  logic [31:0] fine;
  logic [19:0] adc;
  logic        kind;
  logic        guard;
  logic [63:0] ra;
  logic [63:0] rb;
  logic [63:0] rv1;
  logic [63:0] rv2;
  logic [63:0] rs;
  logic [63:0] rd;
  logic [63:0] rn;
  logic [63:0] rp;
  logic [31:0] res_t;
  logic [31:0] res_p;

  logic [31:0] t1;
  logic [31:0] tx;
  logic [31:0] td;
  logic [31:0] fine_new;
  logic [31:0] f5;
  logic [63:0] v1n;
  logic [63:0] pbase;
  logic [63:0] psum;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[4:3])
      bptc_pkg::RegTempCalib: prdata = {16'd0, temp_calib};
      bptc_pkg::RegPressLo:   prdata = press_lo;
      bptc_pkg::RegPressHi:   prdata = press_hi;
      default:                prdata = {48'd0, press_p9};
    endcase
  end

  assign t1       = {16'd0, temp_calib[15:0]};
  assign tx       = {15'd0, adc[19:3]} - {t1[30:0], 1'b0};
  assign td       = {16'd0, adc[19:4]} - t1;
  assign fine_new = ra[31:0] + 32'($signed(prod[31:0]) >>> 14);
  assign f5       = {fine_new[29:0], 2'b00} + fine_new + bptc_pkg::RoundHalf;
  assign v1n      = 64'($signed(prod) >>> 33);
  assign pbase    = {1'b0, 32'(bptc_pkg::PressFull - {12'd0, adc}), 31'd0};
  assign psum     = 64'($signed(rp + ra + 64'($signed(prod) >>> 19)) >>> 8)
                    + (bptc_pkg::sx16(press_hi[47:32]) << 4);

  assign s_tready = (st == SIdle);

  bptc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mstart),
    .a     (ma),
    .b     (mb),
    .done  (mdone),
    .prod  (prod)
  );

  bptc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dstart),
    .num   (rn),
    .den   (rd),
    .done  (ddone),
    .quo   (dq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib <= '0;
      press_lo   <= '0;
      press_hi   <= '0;
      press_p9   <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        bptc_pkg::RegTempCalib: temp_calib <= pwdata[47:0];
        bptc_pkg::RegPressLo:   press_lo   <= pwdata;
        bptc_pkg::RegPressHi:   press_hi   <= pwdata;
        default:                press_p9   <= pwdata[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= SIdle;
      launched <= 1'b0;
      mstart   <= 1'b0;
      dstart   <= 1'b0;
      fine     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      mstart <= 1'b0;
      dstart <= 1'b0;
      if (m_tvalid && m_tready && (st != SDone)) begin
        m_tvalid <= 1'b0;
      end
      case (st)
        SIdle: begin
          if (s_tvalid) begin
            adc  <= s_tdata[19:0];
            kind <= s_tuser;
            st   <= (s_tuser == bptc_pkg::CmdPress) ? SPs : STa;
          end
        end
        STa: begin
          if (!launched) begin
            ma <= bptc_pkg::sx32(tx);
            mb <= bptc_pkg::sx16(temp_calib[31:16]);
            mstart <= 1'b1;
            launched <= 1'b1;
          end else if (mdone) begin
            ra <= bptc_pkg::sx32(32'($signed(prod[31:0]) >>> 11));
            launched <= 1'b0;
            st <= STb;
          end
        end
        STb: begin
          if (!launched) begin
            ma <= bptc_pkg::sx32(td);
            mb <= bptc_pkg::sx32(td);
            mstart <= 1'b1;
            launched <= 1'b1;
          end else if (mdone) begin
            rb <= bptc_pkg::sx32(32'($signed(prod[31:0]) >>> 12));
            launched <= 1'b0;
            st <= STc;
          end
        end
        STc: begin
          if (!launched) begin
            ma <= rb;
            mb <= bptc_pkg::sx16(temp_calib[47:32]);
            mstart <= 1'b1;
            launched <= 1'b1;
          end else if (mdone) begin
            fine  <= fine_new;
            res_t <= 32'($signed(f5) >>> 8);
            res_p <= '0;
            guard <= 1'b0;
            launched <= 1'b0;
            st <= SDone;
          end
        end
        SPs: begin
          if (!launched) begin
            ma <= bptc_pkg::sx32(fine) - bptc_pkg::FineOffset;
            mb <= bptc_pkg::sx32(fine) - bptc_pkg::FineOffset;
            rv1 <= bptc_pkg::sx32(fine) - bptc_pkg::FineOffset;
            mstart <= 1'b1;
            launched <= 1'b1;
          end else if (mdone) begin
            rs <= prod;
            launched <= 1'b0;
            st <= SPv2a;
          end
        end
        SPv2a: begin
          if (!launched) begin
            ma <= rs;
            mb <= bptc_pkg::sx16(press_hi[31:16]);
            mstart <= 1'b1;
            launched <= 1'b1;
          end else if (mdone) begin
            rv2 <= prod;
            launched <= 1'b0;
            st <= SPv2b;
          end
        end
        SPv2b: begin
          if (!launched) begin
            ma <= rv1;
            mb <= bptc_pkg::sx16(press_hi[15:0]);
            mstart <= 1'b1;
            launched <= 1'b1;
          end else if (mdone) begin
            rv2 <= rv2 + {prod[46:0], 17'd0}
                   + (bptc_pkg::sx16(press_lo[63:48]) << 35);
            launched <= 1'b0;
            st <= SPc3;
          end
        end
        SPc3: begin
          if (!launched) begin
            ma <= rs;
            mb <= bptc_pkg::sx16(press_lo[47:32]);
            mstart <= 1'b1;
            launched <= 1'b1;
          end else if (mdone) begin
            ra <= 64'($signed(prod) >>> 8);
            launched <= 1'b0;
            st <= SPc2;
          end
        end
        SPc2: begin
          if (!launched) begin
            ma <= rv1;
            mb <= bptc_pkg::sx16(press_lo[31:16]);
            mstart <= 1'b1;
            launched <= 1'b1;
          end else if (mdone) begin
            ra <= ra + {prod[51:0], 12'd0};
            launched <= 1'b0;
            st <= SPp1;
          end
        end
        SPp1: begin
          if (!launched) begin
            ma <= ra + {16'd1, 48'd0} - {16'd0, 1'b1, 47'd0};
            mb <= {48'd0, press_lo[15:0]};
            mstart <= 1'b1;
            launched <= 1'b1;
          end else if (mdone) begin
            launched <= 1'b0;
            if (v1n == 64'd0) begin
              res_p <= '0;
              res_t <= '0;
              guard <= 1'b1;
              st <= SDone;
            end else begin
              rd <= v1n;
              st <= SPnum;
            end
          end
        end
        SPnum: begin
          if (!launched) begin
            ma <= pbase - rv2;
            mb <= bptc_pkg::PressScale;
            mstart <= 1'b1;
            launched <= 1'b1;
          end else if (mdone) begin
            rn <= prod;
            launched <= 1'b0;
            st <= SPdiv;
          end
        end
        SPdiv: begin
          if (!launched) begin
            dstart <= 1'b1;
            launched <= 1'b1;
          end else if (ddone) begin
            rp <= dq;
            launched <= 1'b0;
            st <= SPq1a;
          end
        end
        SPq1a: begin
          if (!launched) begin
            ma <= 64'($signed(rp) >>> 13);
            mb <= 64'($signed(rp) >>> 13);
            mstart <= 1'b1;
            launched <= 1'b1;
          end else if (mdone) begin
            rs <= prod;
            launched <= 1'b0;
            st <= SPq1b;
          end
        end
        SPq1b: begin
          if (!launched) begin
            ma <= bptc_pkg::sx16(press_p9);
            mb <= rs;
            mstart <= 1'b1;
            launched <= 1'b1;
          end else if (mdone) begin
            ra <= 64'($signed(prod) >>> 25);
            launched <= 1'b0;
            st <= SPq2;
          end
        end
        SPq2: begin
          if (!launched) begin
            ma <= bptc_pkg::sx16(press_hi[63:48]);
            mb <= rp;
            mstart <= 1'b1;
            launched <= 1'b1;
          end else if (mdone) begin
            res_p <= psum[31:0];
            res_t <= '0;
            guard <= 1'b0;
            launched <= 1'b0;
            st <= SDone;
          end
        end
        SDone: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_p, res_t};
            m_tuser  <= {guard, kind};
            st       <= SIdle;
          end
        end
        default: st <= SIdle;
      endcase
    end
  end

endmodule

// File: sv/bptc_mul.sv
// ----------------------------------------------------------------------------
// bptc_mul
// shared 64x64 multiplier keeping the low 64 bits, one 32x32 product a cycle
// ----------------------------------------------------------------------------
module bptc_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);

  logic        busy;
  logic [1:0]  step;
  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] pp;

  always_comb begin
    case (step)
      2'd0: begin
        mx = a[31:0];
        my = b[31:0];
      end
      2'd1: begin
        mx = a[31:0];
        my = b[63:32];
      end
      default: begin
        mx = a[63:32];
        my = b[31:0];
      end
    endcase
  end

  assign pp = mx * my;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        case (step)
          2'd0: begin
            prod <= pp;
            step <= 2'd1;
          end
          2'd1: begin
            prod <= prod + {pp[31:0], 32'd0};
            step <= 2'd2;
          end
          default: begin
            prod <= prod + {pp[31:0], 32'd0};
            busy <= 1'b0;
            done <= 1'b1;
            step <= 2'd0;
          end
        endcase
      end
    end
  end

endmodule

// File: sv/bptc_div.sv
// ----------------------------------------------------------------------------
// bptc_div
// signed truncating 64-bit divider, restoring, one quotient bit a cycle
// ----------------------------------------------------------------------------
module bptc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);

  typedef enum logic [1:0] {
    DIdle,
    DRun,
    DFix
  } dstate_t;

  dstate_t     st;
  logic [6:0]  cnt;
  logic        neg;
  logic [63:0] ad;
  logic [64:0] rem;
  logic [63:0] q;
  logic [64:0] rem_sh;
  logic [64:0] diff;

  assign rem_sh = {rem[63:0], q[63]};
  assign diff   = rem_sh - {1'b0, ad};

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= DIdle;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      case (st)
        DIdle: begin
          if (start) begin
            neg <= num[63] ^ den[63];
            q   <= num[63] ? (64'd0 - num) : num;
            ad  <= den[63] ? (64'd0 - den) : den;
            rem <= '0;
            cnt <= '0;
            st  <= DRun;
          end
        end
        DRun: begin
          if (!diff[64]) begin
            rem <= diff;
          end else begin
            rem <= rem_sh;
          end
          q   <= {q[62:0], ~diff[64]};
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) begin
            st <= DFix;
          end
        end
        DFix: begin
          quo  <= neg ? (64'd0 - q) : q;
          done <= 1'b1;
          st   <= DIdle;
        end
        default: st <= DIdle;
      endcase
    end
  end

endmodule

// File: sv/bptc_checker.sv
// ----------------------------------------------------------------------------
// bptc_checker
// port-level checks for the compensation unit, bound to the top level
// ----------------------------------------------------------------------------
module bptc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [bptc_pkg::OutDataW-1:0] m_tdata,
  input logic [bptc_pkg::OutUserW-1:0] m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output transaction changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a transaction is in work");

  a_temp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == bptc_pkg::CmdTemp) |->
      (m_tdata[63:32] == 32'd0) && !m_tuser[1])
    else $error("temperature result carries pressure data");

  a_guard: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |->
      (m_tuser[0] == bptc_pkg::CmdPress) && (m_tdata == 64'd0))
    else $error("guarded result is not a zero pressure");

endmodule

bind baro_temp_pressure_compensation_unit bptc_checker u_bptc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: test/baro_comp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_comp_checker
// watches the config port and both streams, computes the expected compensated
// temperature and pressure for every accepted sample and compares results
// ----------------------------------------------------------------------------
module baro_comp_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [bptc_pkg::CfgAddrW-1:0] paddr,
  input  logic [bptc_pkg::CfgDataW-1:0] pwdata,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [bptc_pkg::InDataW-1:0]  s_tdata,
  input  logic                          s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [bptc_pkg::OutDataW-1:0] m_tdata,
  input  logic [bptc_pkg::OutUserW-1:0] m_tuser,
  output int                            fail_count,
  output int                            pending,
  output int                            n_temp,
  output int                            n_press,
  output int                            n_guard
);

  typedef struct packed {
    logic        kind;
    logic [31:0] temp_centi;
    logic [31:0] press_q24;
    logic        guard;
  } comp_result_t;

  logic [47:0] t_cal;
  logic [63:0] p_lo, p_hi;
  logic [15:0] p9_cal;
  logic [31:0] t_fine;
  comp_result_t result_q[$];

  function automatic logic signed [31:0] s16_32(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic signed [63:0] s16_64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [31:0] temp_centi_of(input logic [19:0] adc);
    logic signed [31:0] t1, t2, t3, a, d, b, f;
    t1 = {16'd0, t_cal[15:0]};
    t2 = s16_32(t_cal[31:16]);
    t3 = s16_32(t_cal[47:32]);
    a = $signed((({12'd0, adc} >> 3) - (t1 <<< 1)) * t2) >>> 11;
    d = ({12'd0, adc} >> 4) - t1;
    b = (((d * d) >>> 12) * t3) >>> 14;
    f = a + b;
    t_fine = f;
    return (f * 5 + 32'sd128) >>> 8;
  endfunction

  function automatic logic [63:0] sdiv_trunc(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] an, ad, q;
    an = n[63] ? -n : n;
    ad = d[63] ? -d : d;
    q = an / ad;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic comp_result_t press_of(input logic [19:0] adc);
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, q1, q2;
    comp_result_t r;
    r = '0;
    r.kind = bptc_pkg::CmdPress;
    p1 = {48'd0, p_lo[15:0]};
    p2 = s16_64(p_lo[31:16]);
    p3 = s16_64(p_lo[47:32]);
    p4 = s16_64(p_lo[63:48]);
    p5 = s16_64(p_hi[15:0]);
    p6 = s16_64(p_hi[31:16]);
    p7 = s16_64(p_hi[47:32]);
    p8 = s16_64(p_hi[63:48]);
    p9 = s16_64(p9_cal);
    v1 = $signed({{32{t_fine[31]}}, t_fine}) - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    if (v1 == 0) begin
      r.guard = 1'b1;
      return r;
    end
    p = 64'sd1048576 - $signed({44'd0, adc});
    p = sdiv_trunc(((p <<< 31) - v2) * 64'sd3125, v1);
    q1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
    q2 = (p8 * p) >>> 19;
    p = ((p + q1 + q2) >>> 8) + p7 * 64'sd16;
    r.press_q24 = p[31:0];
    return r;
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    comp_result_t e, got;
    if (rst) begin
      t_cal <= '0;
      p_lo <= '0;
      p_hi <= '0;
      p9_cal <= '0;
      t_fine = '0;
      fail_count <= 0;
      n_temp <= 0;
      n_press <= 0;
      n_guard <= 0;
      result_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          bptc_pkg::RegTempCalib: t_cal <= pwdata[47:0];
          bptc_pkg::RegPressLo: p_lo <= pwdata;
          bptc_pkg::RegPressHi: p_hi <= pwdata;
          bptc_pkg::RegPressP9: p9_cal <= pwdata[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == bptc_pkg::CmdTemp) begin
          e = '0;
          e.temp_centi = temp_centi_of(s_tdata[19:0]);
        end else begin
          e = press_of(s_tdata[19:0]);
        end
        result_q.push_back(e);
      end
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser[0];
        got.guard = m_tuser[1];
        got.temp_centi = m_tdata[31:0];
        got.press_q24 = m_tdata[63:32];
        if (result_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          e = result_q.pop_front();
          if (got !== e) begin
            if (fail_count < 10)
              $display("mismatch kind %0d/%0d temp %h/%h press %h/%h guard %0d/%0d (exp/act)",
                       e.kind, got.kind, e.temp_centi, got.temp_centi,
                       e.press_q24, got.press_q24, e.guard, got.guard);
            fail_count <= fail_count + 1;
          end
          if (got.kind == bptc_pkg::CmdTemp) n_temp <= n_temp + 1;
          else n_press <= n_press + 1;
          if (got.guard) n_guard <= n_guard + 1;
        end
      end
    end
  end
endmodule

// File: test/tb_baro_temp_pressure_compensation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_baro_temp_pressure_compensation_unit
// drives calibration writes and raw samples with random gaps and stalls;
// the checker predicts every compensated result and counts mismatches
// ----------------------------------------------------------------------------
module tb_baro_temp_pressure_compensation_unit;

  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [bptc_pkg::CfgAddrW-1:0] paddr = '0;
  logic [bptc_pkg::CfgDataW-1:0] pwdata = '0;
  logic [bptc_pkg::CfgDataW-1:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [bptc_pkg::InDataW-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [bptc_pkg::OutDataW-1:0] m_tdata;
  logic [bptc_pkg::OutUserW-1:0] m_tuser;
  int fail_count, pending, n_temp, n_press, n_guard;
  int cycles = 0;
  logic sink_on = 1'b0;

  always #10 clk = ~clk;

  baro_temp_pressure_compensation_unit i_dut (.*);
  baro_comp_checker i_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result sink with random stalls
  initial begin
    int w;
    wait (sink_on);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic cmd, input logic [19:0] adc, input bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 10) : 0;
    if (w > 0) begin
      s_tvalid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {4'd0, adc};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // corner, realistic-ish or random calibration sets, chosen by mode
  task automatic load_calib(input int mode);
    logic [47:0] tc;
    logic [63:0] lo, hi, p9;
    case (mode)
      0: begin
        tc = '0; lo = '0; hi = '0; p9 = '0;
      end
      1: begin
        tc = {16'hFFFF, 16'hFFFF, 16'hFFFF};
        lo = '1; hi = '1; p9 = 64'hFFFF;
      end
      2: begin
        tc = {16'h8000, 16'h8000, 16'h0000};
        lo = {16'h8000, 16'h8000, 16'h8000, 16'h0001};
        hi = {16'h8000, 16'h8000, 16'h8000, 16'h8000};
        p9 = 64'h8000;
      end
      3: begin
        tc = {16'h7FFF, 16'h7FFF, 16'hFFFF};
        lo = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF};
        hi = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        p9 = 64'h7FFF;
      end
      4: begin
        tc = {16'hFC18, 16'd26435, 16'd27504};
        lo = {16'd2855, 16'd3024, 16'hD5D0, 16'd36477};
        hi = {16'hED75, 16'd15500, 16'hFFF9, 16'd140};
        p9 = 64'd6000;
      end
      default: begin
        tc = 48'({$urandom(), $urandom()});
        lo = {$urandom(), $urandom()};
        hi = {$urandom(), $urandom()};
        p9 = {32'd0, $urandom()};
        if ($urandom_range(0, 1)) begin
          tc[15:0] = 16'd27000 + 16'($urandom_range(0, 1000));
          lo[15:0] = 16'd36000 + 16'($urandom_range(0, 1000));
        end
      end
    endcase
    reg_write(bptc_pkg::RegTempCalib, {16'd0, tc});
    reg_write(bptc_pkg::RegPressLo, lo);
    reg_write(bptc_pkg::RegPressHi, hi);
    reg_write(bptc_pkg::RegPressP9, p9);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    sink_on <= 1'b1;
    @(posedge clk);
    // pressure first with reset calibration gives zero divisor
    send_sample(bptc_pkg::CmdPress, 20'd0, 1'b0);
    drain();
    for (int m = 0; m < 5; m++) begin
      load_calib(m);
      send_sample(bptc_pkg::CmdPress, 20'hFFFFF, 1'b1);
      send_sample(bptc_pkg::CmdTemp, 20'd0, 1'b1);
      send_sample(bptc_pkg::CmdTemp, 20'hFFFFF, 1'b0);
      send_sample(bptc_pkg::CmdPress, 20'd0, 1'b1);
      send_sample(bptc_pkg::CmdTemp, 20'h80000, 1'b1);
      send_sample(bptc_pkg::CmdPress, 20'h55555, 1'b0);
      drain();
    end
    for (int ph = 0; ph < 9; ph++) begin
      load_calib((ph % 3 == 0) ? 4 : 5);
      for (int i = 0; i < 50; i++) begin
        logic [19:0] adc;
        adc = (i % 10 == 0) ? 20'($urandom())
                            : 20'h50000 + 20'($urandom_range(0, 20'h40000));
        send_sample($urandom_range(0, 2) != 0, adc, $urandom_range(0, 4) != 0);
      end
      drain();
    end
    $display("covered %0d temperature and %0d pressure results, %0d zero-divisor guards",
             n_temp, n_press, n_guard);
    $display("calibration: reset, all-ones, min, max, typical and random sets");
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
